>>> src/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg: shared types and constants
// Field widths, result kind codes, job kinds and back-end states for the
// runner-up removal block.
// ----------------------------------------------------------------------------
package trr_pkg;

  // payload widths
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;
  localparam int RANK_W = 2;
  localparam int POS_W  = 5;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_RPT = 2'd0;  // runner-up report
  localparam logic [KIND_W-1:0] KIND_REM = 2'd1;  // remaining element
  localparam logic [KIND_W-1:0] KIND_FEW = 2'd2;  // too few elements
  localparam logic [KIND_W-1:0] KIND_OVF = 2'd3;  // list overflowed

  // list evaluation constants
  localparam int NUM_RUN = 3;   // runner-ups reported
  localparam int MIN_LEN = 4;   // shortest list that is evaluated
  localparam int RES_CAP = 32;  // results per list at most
  localparam logic [POS_W-1:0] REM_LAST = POS_W'(RES_CAP - NUM_RUN - 1);

  // job queue depth
  localparam int JOBQ_DEPTH = 2;

  // job handed from front to back
  typedef enum logic [1:0] {
    JOB_EVAL,
    JOB_FEW,
    JOB_OVF
  } job_kind_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_PICK,
    BK_RPT,
    BK_REM,
    BK_ONE
  } bk_state_t;

endpackage

>>> src/trr_if.sv
// ----------------------------------------------------------------------------
// trr_if: item channels
// Valid/ready channels for list elements and for results.
// ----------------------------------------------------------------------------
interface trr_in_if import trr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface trr_out_if import trr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [KIND_W-1:0] kind;
  logic        [RANK_W-1:0] rank;
  logic signed [DATA_W-1:0] element;
  logic        [POS_W-1:0]  position;
  logic                     final_res;

  modport source (output valid, kind, rank, element, position, final_res, input ready);
  modport sink   (input valid, kind, rank, element, position, final_res, output ready);
endinterface

>>> src/trr_store.sv
// ----------------------------------------------------------------------------
// trr_store: element memory
// One write port from the front, one registered read port for the back.
// ----------------------------------------------------------------------------
module trr_store import trr_pkg::*; #(
  parameter int MAX_LEN = 32,
  localparam int AW = $clog2(MAX_LEN)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [MAX_LEN];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/trr_jobq.sv
// ----------------------------------------------------------------------------
// trr_jobq: job queue
// Short FIFO of closed-list jobs between the front and the back.
// ----------------------------------------------------------------------------
module trr_jobq import trr_pkg::*; #(
  parameter int LW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  job_kind_t     push_kind,
  input  logic [LW-1:0] push_n,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output job_kind_t     head_kind,
  output logic [LW-1:0] head_n
);

  localparam int PW = $clog2(JOBQ_DEPTH);
  localparam int CW = $clog2(JOBQ_DEPTH + 1);

  job_kind_t     kind_q [JOBQ_DEPTH];
  logic [LW-1:0] n_q    [JOBQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr_r] <= push_kind;
      n_q[wr_ptr_r]    <= push_n;
    end
  end

  assign full      = (fill_r == CW'(JOBQ_DEPTH));
  assign empty     = (fill_r == '0);
  assign head_kind = kind_q[rd_ptr_r];
  assign head_n    = n_q[rd_ptr_r];

  // the front and back must respect the queue limits
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("job popped from an empty queue");

endmodule

>>> src/trr_front.sv
// ----------------------------------------------------------------------------
// trr_front: list loader
// Accepts elements, writes them to the store, counts them and classifies
// the closed list into a job for the back.
// ----------------------------------------------------------------------------
module trr_front import trr_pkg::*; #(
  parameter int MAX_LEN = 32,
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  trr_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output job_kind_t         push_kind,
  output logic [LW-1:0]     push_n,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [DATA_W-1:0] wr_data,
  input  logic              release_i
);

  logic [LW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          busy_r, busy_nxt;
  logic          accept;
  logic          room;
  logic [LW-1:0] n_new;

  // the store is owned by the back while an evaluated list is in flight
  assign in_ch.ready = !busy_r && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = (count_r < LW'(MAX_LEN));

  assign wr_en   = accept && room;
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = in_ch.value;
  assign n_new   = room ? count_r + 1'b1 : count_r;

  // job classification on the closing item
  always_comb begin
    push      = accept && in_ch.last;
    push_n    = n_new;
    if (ovf_r || !room) begin
      push_kind = JOB_OVF;
    end else if (n_new < LW'(MIN_LEN)) begin
      push_kind = JOB_FEW;
    end else begin
      push_kind = JOB_EVAL;
    end
  end

  // count, overflow and store ownership
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    busy_nxt  = busy_r;
    if (release_i) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      if (in_ch.last) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        busy_nxt  = (push_kind == JOB_EVAL);
      end else begin
        count_nxt = n_new;
        ovf_nxt   = ovf_r || !room;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

>>> src/trr_back.sv
// ----------------------------------------------------------------------------
// trr_back: evaluation sequencer
// Scans the store four times to pick the maximum and three runner-ups,
// reports them, then streams the remaining elements; other jobs give one result.
// ----------------------------------------------------------------------------
module trr_back import trr_pkg::*; #(
  parameter int MAX_LEN = 32,
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_vld,
  input  job_kind_t         job_kind,
  input  logic [LW-1:0]     job_n,
  output logic              job_pop,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [DATA_W-1:0] rd_data,
  output logic              release_o,
  trr_out_if.source         out_ch
);

  bk_state_t st_r, st_nxt;

  job_kind_t         kind_r, kind_nxt;
  logic [LW-1:0]     n_r, n_nxt;
  logic [LW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]     rd_idx_d_r, rd_idx_d_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [1:0]        pass_r, pass_nxt;
  logic              have_r, have_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [DATA_W-1:0] best_val_r, best_val_nxt;
  logic [MAX_LEN-1:0] taken_r, taken_nxt;
  logic [AW-1:0]     run_idx_r [NUM_RUN];
  logic [AW-1:0]     run_idx_nxt [NUM_RUN];
  logic [DATA_W-1:0] run_val_r [NUM_RUN];
  logic [DATA_W-1:0] run_val_nxt [NUM_RUN];
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [AW-1:0]     keep_r, keep_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic [DATA_W-1:0] out_elem_r, out_elem_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic              out_fin_r, out_fin_nxt;

  logic          slot_free;
  logic          scan_issue, scan_done, scan_better;
  logic          rem_skip, rem_emit, rem_consume, rem_final, rem_issue;
  logic [LW-1:0] cand;
  logic [AW-1:0] last_keep;

  function automatic logic is_run(input logic [AW-1:0] idx,
                                  input logic [AW-1:0] r0,
                                  input logic [AW-1:0] r1,
                                  input logic [AW-1:0] r2);
    return (idx == r0) || (idx == r1) || (idx == r2);
  endfunction

  // handshake and scan control
  assign slot_free   = !out_vld_r || out_ch.ready;
  assign scan_issue  = (st_r == BK_SCAN) && (rd_idx_r < n_r);
  assign scan_done   = (st_r == BK_SCAN) && (rd_idx_r == n_r) && !rd_vld_r;
  assign scan_better = (st_r == BK_SCAN) && rd_vld_r && !taken_r[rd_idx_d_r] &&
                       (!have_r || ($signed(rd_data) > $signed(best_val_r)));

  assign rem_skip    = (st_r == BK_REM) && rd_vld_r &&
                       is_run(rd_idx_d_r, run_idx_r[0], run_idx_r[1], run_idx_r[2]);
  assign rem_emit    = (st_r == BK_REM) && rd_vld_r && !rem_skip && slot_free;
  assign rem_consume = rem_skip || rem_emit;
  assign rem_final   = rem_emit && ((rd_idx_d_r == keep_r) || (pos_r == REM_LAST));
  assign rem_issue   = (st_r == BK_REM) && (rd_idx_r < n_r) &&
                       (!rd_vld_r || rem_consume);

  assign rd_en     = scan_issue || rem_issue;
  assign rd_addr   = rd_idx_r[AW-1:0];
  assign release_o = rem_final;
  assign job_pop   = (st_r == BK_IDLE) && job_vld;

  // highest index that is not a runner-up: the last remaining element
  always_comb begin
    cand      = '0;
    last_keep = keep_r;
    for (int k = NUM_RUN + 1; k >= 1; k--) begin
      cand = n_r - LW'(k);
      if (!is_run(cand[AW-1:0], run_idx_r[0], run_idx_r[1], run_idx_r[2])) begin
        last_keep = cand[AW-1:0];
      end
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (job_vld) begin
          st_nxt = (job_kind == JOB_EVAL) ? BK_SCAN : BK_ONE;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          st_nxt = BK_PICK;
        end
      end
      BK_PICK: begin
        st_nxt = (pass_r == 2'(NUM_RUN)) ? BK_RPT : BK_SCAN;
      end
      BK_RPT: begin
        if (slot_free && (rank_r == RANK_W'(NUM_RUN - 1))) begin
          st_nxt = BK_REM;
        end
      end
      BK_REM: begin
        if (rem_final) begin
          st_nxt = BK_IDLE;
        end
      end
      BK_ONE: begin
        if (slot_free) begin
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_nxt     = kind_r;
    n_nxt        = n_r;
    rd_idx_nxt   = rd_en ? rd_idx_r + 1'b1 : rd_idx_r;
    rd_idx_d_nxt = rd_en ? rd_idx_r[AW-1:0] : rd_idx_d_r;
    rd_vld_nxt   = rd_en || (rd_vld_r && (st_r == BK_REM) && !rem_consume);
    pass_nxt     = pass_r;
    have_nxt     = have_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    taken_nxt    = taken_r;
    run_idx_nxt  = run_idx_r;
    run_val_nxt  = run_val_r;
    rank_nxt     = rank_r;
    keep_nxt     = keep_r;
    pos_nxt      = pos_r;
    out_kind_nxt = out_kind_r;
    out_rank_nxt = out_rank_r;
    out_elem_nxt = out_elem_r;
    out_pos_nxt  = out_pos_r;
    out_fin_nxt  = out_fin_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;

    unique case (st_r)
      BK_IDLE: begin
        if (job_vld) begin
          kind_nxt   = job_kind;
          n_nxt      = job_n;
          rd_idx_nxt = '0;
          pass_nxt   = '0;
          have_nxt   = 1'b0;
          taken_nxt  = '0;
        end
      end
      BK_SCAN: begin
        if (scan_better) begin
          best_idx_nxt = rd_idx_d_r;
          best_val_nxt = rd_data;
          have_nxt     = 1'b1;
        end
      end
      BK_PICK: begin
        // pass 0 finds the maximum, later passes the runner-ups
        taken_nxt[best_idx_r] = 1'b1;
        if (pass_r != '0) begin
          run_idx_nxt[pass_r - 1'b1] = best_idx_r;
          run_val_nxt[pass_r - 1'b1] = best_val_r;
        end
        pass_nxt   = pass_r + 1'b1;
        have_nxt   = 1'b0;
        rd_idx_nxt = '0;
        rank_nxt   = '0;
      end
      BK_RPT: begin
        keep_nxt = last_keep;
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = KIND_RPT;
          out_rank_nxt = rank_r + 1'b1;
          out_elem_nxt = run_val_r[rank_r];
          out_pos_nxt  = POS_W'(run_idx_r[rank_r]);
          out_fin_nxt  = 1'b0;
          rank_nxt     = rank_r + 1'b1;
          rd_idx_nxt   = '0;
          pos_nxt      = '0;
        end
      end
      BK_REM: begin
        if (rem_emit) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = KIND_REM;
          out_rank_nxt = '0;
          out_elem_nxt = rd_data;
          out_pos_nxt  = pos_r;
          out_fin_nxt  = rem_final;
          pos_nxt      = pos_r + 1'b1;
        end
      end
      BK_ONE: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = (kind_r == JOB_OVF) ? KIND_OVF : KIND_FEW;
          out_rank_nxt = '0;
          out_elem_nxt = '0;
          out_pos_nxt  = '0;
          out_fin_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_IDLE;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    n_r        <= n_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_idx_d_r <= rd_idx_d_nxt;
    pass_r     <= pass_nxt;
    have_r     <= have_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    taken_r    <= taken_nxt;
    run_idx_r  <= run_idx_nxt;
    run_val_r  <= run_val_nxt;
    rank_r     <= rank_nxt;
    keep_r     <= keep_nxt;
    pos_r      <= pos_nxt;
    out_kind_r <= out_kind_nxt;
    out_rank_r <= out_rank_nxt;
    out_elem_r <= out_elem_nxt;
    out_pos_r  <= out_pos_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.rank      = out_rank_r;
  assign out_ch.element   = out_elem_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.final_res = out_fin_r;

  // three distinct runner-ups while the remaining elements stream
  a_run_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_REM) |-> (run_idx_r[0] != run_idx_r[1]) &&
                         (run_idx_r[0] != run_idx_r[2]) &&
                         (run_idx_r[1] != run_idx_r[2]))
    else $error("runner-up indices collide");
  // the closing element must be one that is emitted
  a_keep_not_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_REM) |-> !is_run(keep_r, run_idx_r[0], run_idx_r[1], run_idx_r[2]))
    else $error("last kept element is a runner-up");
  // store is released only with the closing result of an evaluated list
  a_release_final: assert property (@(posedge clk) disable iff (!rst_n)
    release_o |=> out_vld_r && out_fin_r && (out_kind_r == KIND_REM))
    else $error("store released without a final result");

endmodule

>>> src/top_runner_up_removal.sv
// ----------------------------------------------------------------------------
// top_runner_up_removal: runner-up report and removal
// Loads a list, reports its first three runner-ups and streams the rest.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  in_ch     in   value[31:0] signed, last                  valid/ready
//  out_ch    out  kind, rank, element, position, final_res  valid/ready
//
//  Loading accepts one element per cycle unless the input stalls. A closed
//  list of n elements becomes a job: four scans (reads, latency, close, pick),
//  three runner-up reports and a removal pass, all paced by the single store
//  read port. Error lists (too few, overflow) give one result.
//  Reset is synchronous, active low; the store needs no clearing. Input stalls
//  while an evaluated list owns the store or the job queue is full.
// ----------------------------------------------------------------------------
module top_runner_up_removal import trr_pkg::*; #(
  parameter int MAX_LEN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  trr_in_if.sink    in_ch,
  trr_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic              push, q_full, q_empty, pop;
  job_kind_t         push_kind, head_kind;
  logic [LW-1:0]     push_n, head_n;
  logic              wr_en, rd_en, rel;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  trr_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_kind (push_kind),
    .push_n    (push_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .release_i (rel)
  );

  trr_store #(.MAX_LEN(MAX_LEN)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  trr_jobq #(.LW(LW)) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_kind (push_kind),
    .push_n    (push_n),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head_kind (head_kind),
    .head_n    (head_n)
  );

  trr_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (!q_empty),
    .job_kind  (head_kind),
    .job_n     (head_n),
    .job_pop   (pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .release_o (rel),
    .out_ch    (out_ch)
  );

endmodule

>>> sim/tb_top_runner_up_removal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_runner_up_removal: runner-up report and removal testbench
// Feeds signed lists through the valid/ready input channel and ranks each
// closed list in a local copy of the list store. Every result item is checked
// field by field against the oldest ranked result. Both channels idle at
// random, and the receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top_runner_up_removal;
  import trr_pkg::*;

  localparam int LIST_CAP      = 32;      // MAX_LEN of the block under test
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 300;
  localparam int SETTLE_CYCLES = 200;     // longest list evaluation plus margin
  localparam int CYCLE_LIMIT   = 300000;

  // value styles for random lists
  localparam int VAL_WIDE    = 0;
  localparam int VAL_NARROW  = 1;  // small range, many equal values
  localparam int VAL_EXTREME = 2;

  // receiver stall patterns
  localparam int RX_OPEN     = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [RANK_W-1:0]        rank;
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         position;
    logic                     final_res;
  } ranked_item_t;

  logic clk;
  logic rst_n;

  trr_in_if  in_ch ();
  trr_out_if out_ch ();

  top_runner_up_removal #(.MAX_LEN(LIST_CAP)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local list store and ranked results still to come
  logic signed [DATA_W-1:0] list_mem [LIST_CAP];
  int                       list_len     = 0;
  bit                       list_dropped = 0;
  ranked_item_t             ranked_q [$];

  int fail_cnt   = 0;
  int items_sent = 0;
  int cycle_cnt  = 0;
  int rx_hold    = 0;  // receiver hold-off, in cycles
  int tx_burst   = 0;  // items left in the current sender burst
  bit tx_steady  = 0;  // sender offers back to back

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void push_ranked(logic [KIND_W-1:0] kind, logic [RANK_W-1:0] rank,
                                      logic signed [DATA_W-1:0] element, int position,
                                      bit fin);
    ranked_item_t r;
    r.kind      = kind;
    r.rank      = rank;
    r.element   = element;
    r.position  = POS_W'(position);
    r.final_res = fin;
    ranked_q.push_back(r);
  endfunction

  // store one element; on the closing item rank the list and queue its results
  function automatic void absorb_element(logic signed [DATA_W-1:0] value, logic last);
    int        n;
    int        best;
    int        total;
    int        k;
    int        pos;
    int        runner [NUM_RUN];
    bit [63:0] taken;
    if (list_len < LIST_CAP) begin
      list_mem[list_len] = value;
      list_len++;
    end else begin
      list_dropped = 1'b1;
    end
    if (!last) return;

    n = list_len;
    list_len = 0;
    if (list_dropped) begin
      list_dropped = 1'b0;
      push_ranked(KIND_OVF, '0, '0, 0, 1'b1);
      return;
    end
    if (n < MIN_LEN) begin
      push_ranked(KIND_FEW, '0, '0, 0, 1'b1);
      return;
    end

    // first pick is the maximum, the next three are the runner-ups
    taken = '0;
    for (int p = 0; p <= NUM_RUN; p++) begin
      best = -1;
      for (int i = 0; i < n; i++)
        if (!taken[i] && (best < 0 || list_mem[i] > list_mem[best])) best = i;
      taken[best] = 1'b1;
      if (p > 0) runner[p-1] = best;
    end

    total = NUM_RUN + (n - NUM_RUN);
    if (total > RES_CAP) total = RES_CAP;
    k = 0;
    for (int r = 0; r < NUM_RUN; r++) begin
      push_ranked(KIND_RPT, RANK_W'(r + 1), list_mem[runner[r]], runner[r], k == total - 1);
      k++;
    end
    // remaining elements in order, maximum included
    pos = 0;
    for (int i = 0; i < n && k < RES_CAP; i++) begin
      if (i == runner[0] || i == runner[1] || i == runner[2]) continue;
      push_ranked(KIND_REM, '0, list_mem[i], pos, k == total - 1);
      pos++;
      k++;
    end
  endfunction

  // result checker
  ranked_item_t want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (ranked_q.size() == 0) begin
        $error("unexpected result item: kind %0d rank %0d element %0d position %0d",
               out_ch.kind, out_ch.rank, out_ch.element, out_ch.position);
        fail_cnt++;
      end else begin
        want = ranked_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
          fail_cnt++;
        end
        if (out_ch.rank !== want.rank) begin
          $error("rank: expected %0d, actual %0d", want.rank, out_ch.rank);
          fail_cnt++;
        end
        if (out_ch.element !== want.element) begin
          $error("element: expected %0d, actual %0d", want.element, out_ch.element);
          fail_cnt++;
        end
        if (out_ch.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_ch.position);
          fail_cnt++;
        end
        if (out_ch.final_res !== want.final_res) begin
          $error("final_res: expected %0d, actual %0d", want.final_res, out_ch.final_res);
          fail_cnt++;
        end
      end
    end
  end

  // receiver: changing stall patterns, plus a hold-off on request
  initial begin : rx_stall
    int mode;
    int span;
    int phase;
    mode  = RX_OPEN;
    span  = 0;
    phase = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(RX_OPEN, RX_PERIODIC);
          span = $urandom_range(20, 150);
        end
        span--;
        phase++;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 9) < 6);
          default:   out_ch.ready <= ((phase % 5) < 3);
        endcase
      end
    end
  end

  // offer one item, with a random gap at the start of each burst
  task automatic send_item(input logic signed [DATA_W-1:0] value, input logic last);
    int gap;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 16);
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst--;
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_element(value, last);
    items_sent++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(int style);
    logic signed [DATA_W-1:0] v;
    case (style)
      VAL_WIDE:   v = $urandom;
      VAL_NARROW: v = $signed(DATA_W'($urandom_range(0, 6))) - 3;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = MIN_VAL;
          1:       v = MAX_VAL;
          2:       v = '0;
          3:       v = -1;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_list(input int len, input int style);
    for (int i = 0; i < len; i++) send_item(pick_value(style), i == len - 1);
  endtask

  // stop offering until every ranked result has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    tx_burst = 0;
    @(posedge clk);
    while (ranked_q.size() != 0) @(posedge clk);
  endtask

  // lists shorter than four elements
  task automatic test_too_few();
    send_item(5, 1'b1);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(1, 1'b1);
  endtask

  // most negative and most positive values in one list
  task automatic test_extremes();
    send_item(MIN_VAL, 1'b0);
    send_item(MAX_VAL, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b1);
  endtask

  // all equal: lowest index wins every pick
  task automatic test_ties();
    for (int i = 0; i < 5; i++) send_item(7, i == 4);
  endtask

  // rising list, maximum at the end
  task automatic test_ascending();
    for (int i = 1; i <= 6; i++) send_item(i, i == 6);
  endtask

  // list exactly at capacity: most results per list
  task automatic test_full_list();
    send_list(LIST_CAP, VAL_WIDE);
  endtask

  // one item past capacity, then a normal list to show recovery
  task automatic test_overflow();
    send_list(LIST_CAP + 1, VAL_EXTREME);
    send_list(MIN_LEN, VAL_NARROW);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    wait_drained();
    rx_hold = 400;
    tx_steady = 1'b1;
    send_list(LIST_CAP, VAL_WIDE);
    send_list(9, VAL_NARROW);
    send_list(6, VAL_EXTREME);
    tx_steady = 1'b0;
    wait_drained();
  endtask

  // mostly well-formed lists, some short or overflowing ones
  task automatic test_random_lists(input int target);
    int start;
    int sel;
    int len;
    start = items_sent;
    while (items_sent - start < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 6)       len = $urandom_range(1, MIN_LEN - 1);
      else if (sel < 10) len = $urandom_range(LIST_CAP + 1, LIST_CAP + 4);
      else if (sel < 14) len = LIST_CAP;
      else               len = $urandom_range(MIN_LEN, 12);
      tx_steady = ($urandom_range(0, 3) == 0);
      send_list(len, $urandom_range(VAL_WIDE, VAL_EXTREME));
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    tx_steady = 1'b0;
  endtask

  // test sequence
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    rst_n       <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_too_few();
    test_extremes();
    test_ties();
    test_ascending();
    test_full_list();
    test_overflow();
    test_backpressure();
    test_random_lists(RANDOM_ITEMS);

    // drain, then watch for stray results
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/trr_pkg.sv
src/trr_if.sv
src/trr_store.sv
src/trr_jobq.sv
src/trr_front.sv
src/trr_back.sv
src/top_runner_up_removal.sv
sim/tb_top_runner_up_removal.sv
